// ----- hdl/sequential_list_engine_top_defines.svh -----
// Assertion macros for the list engine.
`ifndef SEQUENTIAL_LIST_ENGINE_TOP_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_TOP_DEFINES_SVH
// Check that a condition implies a consequence on the same edge.
`define SLE_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("lbl");
// Check that a condition implies a consequence on the next edge.
`define SLE_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("lbl");
`endif

// ----- hdl/sle_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sle_pkg;
  typedef enum logic [3:0] {
    CMD_APPEND = 4'd0, CMD_INSERT_AT = 4'd1, CMD_REMOVE_FIRST = 4'd2,
    CMD_REMOVE_AT = 4'd3, CMD_REMOVE_ALL = 4'd4, CMD_REVERSE = 4'd5,
    CMD_INS_AFTER_FIRST = 4'd6, CMD_INS_AFTER_ALL = 4'd7, CMD_READ = 4'd8
  } cmd_t;
  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOKEY = 2'd1, ST_FULL = 2'd2, ST_BADPOS = 2'd3
  } status_t;
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN, S_SCAN_WAIT, S_DECIDE, S_SHIFT, S_RD_WAIT,
    S_WALK, S_WALK_WR, S_COPY, S_COPY_WR, S_REV, S_REV_B, S_REV_WR, S_REV_TAIL,
    S_DONE
  } state_t;
  typedef struct packed {
    logic [3:0]  cmd;
    logic [6:0]  position;
    logic [31:0] key;
    logic [31:0] value;
  } item_t;
  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  count;
    logic [31:0] read_value;
  } result_t;
endpackage
`default_nettype wire

// ----- hdl/sle_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Accept command beats and hold them in a two-entry queue.
module sle_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sle_pkg::item_t in_item,
  output logic               q_valid,
  input  wire logic          q_pop,
  output sle_pkg::item_t     q_item
);
  import sle_pkg::*;
  item_t      buf_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = buf_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ (q_pop && q_valid);
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= in_item;
  end
endmodule
`default_nettype wire

// ----- hdl/sle_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Execute one command against the element memory with a small sequencer.
module sle_back #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire sle_pkg::item_t  q_item,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output sle_pkg::result_t     res
);
  import sle_pkg::*;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = 7;
  localparam int HW = CW + 1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] scr [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q, srd_q;

  state_t                state_r, state_nxt;
  item_t                 it_r, it_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         i_r, i_nxt, j_r, j_nxt;
  logic [HW-1:0]         hits_r, hits_nxt;
  logic                  found_r, found_nxt;
  logic [CW-1:0]         fidx_r, fidx_nxt;
  logic [1:0]            st_r, st_nxt;
  logic [DATA_WIDTH-1:0] rv_r, rv_nxt, tmp_r, tmp_nxt;
  logic                  ins_r, ins_nxt;
  logic                  rvalid_r, rvalid_nxt;

  logic                  mwe, swe;
  logic [AW-1:0]         mwa, mra, swa, sra;
  logic [DATA_WIDTH-1:0] mwd, swd;

  logic [DATA_WIDTH-1:0] keyw, valw;
  logic [PW-1:0]         pos;
  logic [CW:0]           cnt_ext;
  assign keyw    = DATA_WIDTH'(signed'(it_r.key));
  assign valw    = DATA_WIDTH'(signed'(it_r.value));
  assign pos     = it_r.position;
  assign cnt_ext = {1'b0, cnt_r};

  assign res_valid      = rvalid_r;
  assign res.status     = st_r;
  assign res.count      = PW'(cnt_r);
  assign res.read_value = 32'(signed'(rv_r));

  always_ff @(posedge clk) begin
    if (mwe) mem[mwa] <= mwd;
    rd_q <= mem[mra];
    if (swe) scr[swa] <= swd;
    srd_q <= scr[sra];
  end

  always_comb begin
    state_nxt = state_r; it_nxt = it_r; cnt_nxt = cnt_r;
    i_nxt = i_r; j_nxt = j_r; hits_nxt = hits_r; found_nxt = found_r;
    fidx_nxt = fidx_r; st_nxt = st_r; rv_nxt = rv_r; tmp_nxt = tmp_r;
    ins_nxt = ins_r; rvalid_nxt = rvalid_r;
    q_pop = 1'b0;
    mwe = 1'b0; mwa = '0; mwd = valw; mra = AW'(i_r);
    swe = 1'b0; swa = AW'(j_r); swd = rd_q; sra = AW'(i_r);
    if (rvalid_r && res_ready) rvalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid && !rvalid_r) begin
          q_pop = 1'b1; it_nxt = q_item; state_nxt = S_CHECK;
          st_nxt = ST_OK; rv_nxt = '0; i_nxt = '0; j_nxt = '0;
          hits_nxt = '0; found_nxt = 1'b0;
        end
      end
      S_CHECK: begin
        state_nxt = S_DONE;
        case (it_r.cmd)
          CMD_APPEND, CMD_INSERT_AT: begin
            if (it_r.cmd == CMD_INSERT_AT &&
                (pos == '0 || (CW + 1)'(pos) > cnt_ext + 1'b1)) st_nxt = ST_BADPOS;
            else if (cnt_ext >= (CW + 1)'(DEPTH)) st_nxt = ST_FULL;
            else begin
              fidx_nxt = (it_r.cmd == CMD_APPEND) ? cnt_r : CW'(pos - 1'b1);
              i_nxt = cnt_r; ins_nxt = 1'b1; state_nxt = S_SHIFT;
            end
          end
          CMD_REMOVE_AT, CMD_READ: begin
            if (pos == '0 || (CW + 1)'(pos) > cnt_ext) st_nxt = ST_BADPOS;
            else begin
              fidx_nxt = CW'(pos - 1'b1); i_nxt = CW'(pos - 1'b1);
              ins_nxt = 1'b0;
              state_nxt = (it_r.cmd == CMD_READ) ? S_RD_WAIT : S_SHIFT;
            end
          end
          CMD_REMOVE_FIRST, CMD_INS_AFTER_FIRST, CMD_INS_AFTER_ALL,
          CMD_REMOVE_ALL: begin
            state_nxt = (cnt_r == '0) ? S_DECIDE : S_SCAN;
          end
          CMD_REVERSE: begin
            j_nxt = cnt_r - 1'b1;
            state_nxt = (cnt_r < CW'(2)) ? S_DONE : S_REV;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        mra = AW'(i_r); state_nxt = S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        if (rd_q == keyw) begin
          hits_nxt = hits_r + 1'b1;
          if (!found_r) begin found_nxt = 1'b1; fidx_nxt = i_r; end
        end
        if (it_r.cmd == CMD_REMOVE_ALL) begin
          if (rd_q != keyw) begin
            swe = 1'b1; swa = AW'(j_r); swd = rd_q; j_nxt = j_r + 1'b1;
          end
        end else if (it_r.cmd == CMD_INS_AFTER_ALL) begin
          swe = 1'b1; swa = AW'(j_r); swd = rd_q;
          if (rd_q == keyw) begin
            ins_nxt = 1'b1; tmp_nxt = valw;
          end
          j_nxt = j_r + 1'b1;
        end
        i_nxt = i_r + 1'b1;
        state_nxt = S_SCAN;
        if (it_r.cmd == CMD_INS_AFTER_ALL && rd_q == keyw) state_nxt = S_WALK_WR;
        else if (i_r + 1'b1 == cnt_r) state_nxt = S_DECIDE;
        if ((it_r.cmd == CMD_REMOVE_FIRST || it_r.cmd == CMD_INS_AFTER_FIRST)
            && rd_q == keyw && !found_r) state_nxt = S_DECIDE;
      end
      S_WALK_WR: begin
        if ({1'b0, j_r} < (CW + 1)'(DEPTH)) begin
          swe = 1'b1; swa = AW'(j_r); swd = tmp_r;
        end
        j_nxt = j_r + 1'b1;
        state_nxt = (i_r == cnt_r) ? S_DECIDE : S_SCAN;
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        if (hits_r == '0) st_nxt = ST_NOKEY;
        else case (it_r.cmd)
          CMD_REMOVE_FIRST: begin
            i_nxt = fidx_r; ins_nxt = 1'b0; state_nxt = S_SHIFT;
          end
          CMD_INS_AFTER_FIRST: begin
            if (cnt_ext >= (CW + 1)'(DEPTH)) st_nxt = ST_FULL;
            else begin
              fidx_nxt = fidx_r + 1'b1; i_nxt = cnt_r; ins_nxt = 1'b1;
              state_nxt = S_SHIFT;
            end
          end
          CMD_REMOVE_ALL: begin
            cnt_nxt = CW'(j_r); i_nxt = '0; state_nxt = S_COPY;
            if (j_r == '0) state_nxt = S_DONE;
          end
          CMD_INS_AFTER_ALL: begin
            if ((CW + 2)'(cnt_r) + (CW + 2)'(hits_r) > (CW + 2)'(DEPTH))
              st_nxt = ST_FULL;
            else begin cnt_nxt = CW'(j_r); i_nxt = '0; state_nxt = S_COPY; end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_COPY: begin
        sra = AW'(i_r); state_nxt = S_COPY_WR;
      end
      S_COPY_WR: begin
        mwe = 1'b1; mwa = AW'(i_r); mwd = srd_q; i_nxt = i_r + 1'b1;
        state_nxt = (i_r + 1'b1 == cnt_r) ? S_DONE : S_COPY;
      end
      S_SHIFT: begin
        // insert walks down from the tail, remove walks up from the hole
        if (ins_r) begin
          if (i_r == fidx_r) begin
            mwe = 1'b1; mwa = AW'(fidx_r); mwd = valw;
            cnt_nxt = cnt_r + 1'b1; state_nxt = S_DONE;
          end else begin
            mra = AW'(i_r - 1'b1); state_nxt = S_WALK;
          end
        end else begin
          if (i_r + 1'b1 >= cnt_r) begin
            cnt_nxt = cnt_r - 1'b1; state_nxt = S_DONE;
          end else begin
            mra = AW'(i_r + 1'b1); state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        mwe = 1'b1; mwa = AW'(i_r); mwd = rd_q;
        i_nxt = ins_r ? i_r - 1'b1 : i_r + 1'b1;
        state_nxt = S_SHIFT;
      end
      S_RD_WAIT: state_nxt = S_COPY_WR;
      S_REV: begin
        mra = AW'(i_r); state_nxt = S_REV_B;
      end
      S_REV_B: begin
        tmp_nxt = rd_q; mra = AW'(j_r); state_nxt = S_REV_WR;
      end
      S_REV_WR: begin
        mwe = 1'b1; mwa = AW'(i_r); mwd = rd_q;
        state_nxt = S_REV_TAIL;
      end
      S_REV_TAIL: begin
        // second half of the swap, then move both ends inward
        mwe = 1'b1; mwa = AW'(j_r); mwd = tmp_r;
        i_nxt = i_r + 1'b1; j_nxt = j_r - 1'b1;
        state_nxt = (i_r + 1'b1 < j_r - 1'b1) ? S_REV : S_DONE;
      end
      S_DONE: begin
        if (!rvalid_r) begin rvalid_nxt = 1'b1; state_nxt = S_IDLE; end
      end
      default: state_nxt = S_IDLE;
    endcase
    // read data path
    if (state_r == S_COPY_WR && it_r.cmd == CMD_READ) begin
      mwe = 1'b0; rv_nxt = rd_q; state_nxt = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; rvalid_r <= 1'b0; ins_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; rvalid_r <= rvalid_nxt;
      ins_r <= ins_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r <= it_nxt; i_r <= i_nxt; j_r <= j_nxt; hits_r <= hits_nxt;
    found_r <= found_nxt; fidx_r <= fidx_nxt; st_r <= st_nxt;
    rv_r <= rv_nxt; tmp_r <= tmp_nxt;
  end
endmodule
`default_nettype wire

// ----- hdl/sequential_list_engine_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Packed list engine: each command beat on in_ returns one result beat on
// out_ with a status, the new count and the value read. A two-entry queue
// takes beats while the sequencer works on the memory; the next command
// starts only once the previous result beat has left. Every memory read goes
// through a registered read port; remove-all and insert-after-all scan the
// list, then copy it back through a scratch memory.
module sequential_list_engine_top #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // cmd[3:0], position[10:4], key[42:11], value[74:43], zero fill
  input  wire logic [79:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[1:0], count[8:2], read_value[40:9], zero fill
  output logic [47:0]      out_tdata
);
  import sle_pkg::*;
  `include "sequential_list_engine_top_defines.svh"

  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_pop;

  assign in_item.cmd      = in_tdata[3:0];
  assign in_item.position = in_tdata[10:4];
  assign in_item.key      = in_tdata[42:11];
  assign in_item.value    = in_tdata[74:43];

  sle_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .in_item, .q_valid, .q_pop, .q_item
  );

  sle_back #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item,
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );

  assign out_tdata = {7'd0, res.read_value, res.count, res.status};

  `SLE_ASSERT_IMP(a_count_range, out_tvalid, out_tdata[8:2] <= 7'(DEPTH))
  `SLE_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `SLE_ASSERT_IMP(a_pop_has_item, q_pop, q_valid)
endmodule
`default_nettype wire

// ----- verif/list_checker.sv -----
`timescale 1ns / 1ps
module list_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [79:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [47:0] out_tdata,
  output int               fail_count,
  output int               pending,
  output int               results_seen
);
  import sle_pkg::*;
  localparam int DEPTH = 64;

  logic [31:0] model_list [DEPTH];
  int          model_count;
  result_t     expected_results [$];

  initial begin
    fail_count   = 0;
    results_seen = 0;
    model_count  = 0;
    pending      = 0;
  end

  function automatic result_t apply_command(logic [79:0] beat);
    result_t     r;
    logic [3:0]  cmd;
    int          pos;
    logic [31:0] key;
    logic [31:0] val;
    logic [31:0] tmp [DEPTH];
    int          k;
    int          idx;
    int          hits;
    logic [31:0] t;
    cmd = beat[3:0];
    pos = beat[10:4];
    key = beat[42:11];
    val = beat[74:43];
    r.status = ST_OK;
    r.read_value = '0;
    idx = -1;
    hits = 0;
    k = 0;
    for (int i = 0; i < model_count; i++) begin
      if (model_list[i] == key) begin
        if (idx < 0) idx = i;
        hits++;
      end
    end
    case (cmd)
      CMD_APPEND: begin
        if (model_count >= DEPTH) r.status = ST_FULL;
        else model_list[model_count++] = val;
      end
      CMD_INSERT_AT, CMD_INS_AFTER_FIRST: begin
        if (cmd == CMD_INSERT_AT && (pos < 1 || pos > model_count + 1)) r.status = ST_BADPOS;
        else if (cmd == CMD_INS_AFTER_FIRST && idx < 0) r.status = ST_NOKEY;
        else if (model_count >= DEPTH) r.status = ST_FULL;
        else begin
          if (cmd == CMD_INSERT_AT) idx = pos - 1;
          else idx = idx + 1;
          for (int j = model_count; j > idx; j--) model_list[j] = model_list[j-1];
          model_list[idx] = val;
          model_count++;
        end
      end
      CMD_REMOVE_FIRST, CMD_REMOVE_AT: begin
        if (cmd == CMD_REMOVE_AT && (pos < 1 || pos > model_count)) r.status = ST_BADPOS;
        else if (cmd == CMD_REMOVE_FIRST && idx < 0) r.status = ST_NOKEY;
        else begin
          if (cmd == CMD_REMOVE_AT) idx = pos - 1;
          for (int j = idx; j + 1 < model_count; j++) model_list[j] = model_list[j+1];
          model_count--;
        end
      end
      CMD_REMOVE_ALL, CMD_INS_AFTER_ALL: begin
        if (hits == 0) r.status = ST_NOKEY;
        else if (cmd == CMD_INS_AFTER_ALL && model_count + hits > DEPTH) r.status = ST_FULL;
        else begin
          for (int i = 0; i < model_count; i++) begin
            if (model_list[i] != key) begin
              tmp[k] = model_list[i];
              k++;
            end else if (cmd == CMD_INS_AFTER_ALL) begin
              tmp[k] = model_list[i];
              tmp[k+1] = val;
              k += 2;
            end
          end
          model_count = k;
          for (int i = 0; i < model_count; i++) model_list[i] = tmp[i];
        end
      end
      CMD_REVERSE: begin
        for (int i = 0; i < model_count / 2; i++) begin
          t = model_list[i];
          model_list[i] = model_list[model_count-1-i];
          model_list[model_count-1-i] = t;
        end
      end
      CMD_READ: begin
        if (pos < 1 || pos > model_count) r.status = ST_BADPOS;
        else r.read_value = model_list[pos-1];
      end
      default: ;
    endcase
    r.count = model_count[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [40:0] got, logic [40:0] want);
    $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && in_tvalid && in_tready)
      expected_results.push_back(apply_command(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      got.status     = out_tdata[1:0];
      got.count      = out_tdata[8:2];
      got.read_value = out_tdata[40:9];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", got, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.count != want.count) report_mismatch("count", got.count, want.count);
        if (got.read_value != want.read_value)
          report_mismatch("read_value", got.read_value, want.read_value);
      end
      results_seen++;
    end
    pending = expected_results.size();
  end
endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import sle_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [79:0] in_tdata = '0;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [47:0] out_tdata;

  int fail_count;
  int pending;
  int results_seen;
  int send_idle_pct = 18;
  int recv_idle_pct = 55;
  int hold_off_cycles = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  logic [31:0] key_pool [4];

  // Toggle the clock every half period of a 4 ns cycle.
  always #2 clk = ~clk;

  sequential_list_engine_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  list_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  // Drop ready at random, or hold it low for a forced long stretch.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Count cycles without any accepted beat; end the run when they pile up.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", idle_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one command beat and hold it until accepted; gaps come first.
  task automatic send_beat(cmd_t cmd, int pos, logic [31:0] key, logic [31:0] val);
    logic [3:0] raw;
    raw = cmd;
    send_raw(raw, pos, key, val);
  endtask

  task automatic send_raw(logic [3:0] cmd, int pos, logic [31:0] key, logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, val, key, pos[6:0], cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic release_valid();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    release_valid();
    while (pending > 0) @(posedge clk);
  endtask

  // Pick a key that often matches a stored value.
  function automatic logic [31:0] pick_word();
    if ($urandom_range(3) != 0) return key_pool[$urandom_range(3)];
    return $urandom;
  endfunction

  task automatic random_item();
    int   sel;
    int   pos;
    logic [3:0] cmd;
    sel = $urandom_range(99);
    if (sel < 25) cmd = CMD_APPEND;
    else if (sel < 35) cmd = CMD_INSERT_AT;
    else if (sel < 90) cmd = 4'($urandom_range(8));
    else cmd = 4'($urandom_range(15));
    if ($urandom_range(9) == 0) pos = $urandom_range(127);
    else pos = $urandom_range(66);
    send_raw(cmd, pos, pick_word(), pick_word());
  endtask

  initial begin
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = $urandom;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list cases, field extremes, every command.
    send_beat(CMD_REVERSE, 1, 0, 0);
    send_beat(CMD_READ, 1, 0, 0);
    send_beat(CMD_REMOVE_AT, 0, 0, 0);
    send_beat(CMD_REMOVE_FIRST, 1, 32'h8000_0000, 0);
    send_beat(CMD_INSERT_AT, 2, 0, 32'h1234_5678);
    send_beat(CMD_INSERT_AT, 1, 0, 32'h8000_0000);
    send_beat(CMD_APPEND, 1, 0, 32'h7fff_ffff);
    send_beat(CMD_INSERT_AT, 3, 0, 32'hffff_ffff);
    send_beat(CMD_INS_AFTER_FIRST, 1, 32'h7fff_ffff, 32'h7fff_ffff);
    send_beat(CMD_INS_AFTER_ALL, 1, 32'h7fff_ffff, 32'h5555_aaaa);
    send_beat(CMD_INS_AFTER_ALL, 1, 32'h0bad_0bad, 1);
    send_beat(CMD_READ, 127, 0, 0);
    send_beat(CMD_READ, 2, 0, 0);
    send_beat(CMD_REVERSE, 1, 0, 0);
    send_beat(CMD_REMOVE_ALL, 1, 32'h7fff_ffff, 0);
    send_beat(CMD_REMOVE_AT, 1, 0, 0);
    send_raw(4'hf, 127, 32'hffff_ffff, 32'hffff_ffff);
    send_raw(4'h9, 0, 0, 0);
    // Fill to the top, then hit the full checks.
    for (int i = 0; i < 64; i++) send_beat(CMD_APPEND, 1, 0, i[0] ? 32'h8000_0000 : $urandom);
    send_beat(CMD_APPEND, 1, 0, 0);
    send_beat(CMD_INSERT_AT, 65, 0, 0);
    send_beat(CMD_INSERT_AT, 66, 0, 0);
    send_beat(CMD_INS_AFTER_FIRST, 1, 32'h8000_0000, 0);
    send_beat(CMD_REMOVE_FIRST, 1, 32'h8000_0000, 0);
    send_beat(CMD_INS_AFTER_ALL, 1, 32'h8000_0000, 0);
    send_beat(CMD_READ, 63, 0, 0);
    send_beat(CMD_REMOVE_ALL, 1, 32'h8000_0000, 0);
    // Sender pauses until everything is back.
    drain();

    // Long receiver hold-off while the sender keeps offering beats.
    hold_off_cycles = 400;
    for (int i = 0; i < 20; i++) random_item();

    for (int i = 0; i < 1650; i++) begin
      if (i == 550) begin
        send_idle_pct = 55;
        recv_idle_pct = 18;
      end
      if (i == 1100) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i % 200 == 0) key_pool[3] = $urandom;
      random_item();
    end
    drain();
    repeat (300) @(posedge clk);

    $display("ran %0d commands over every opcode, full and empty lists, bad positions,",
             items_sent);
    $display("missing keys and three idling patterns; %0d results checked", results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
